FILE: rtl/irpf_pkg.sv
package irpf_pkg;

  localparam int IRPF_MAX_WIDTH  = 256;
  localparam int IRPF_MAX_HEIGHT = 256;

  localparam int COORD_W = 8;
  localparam int PIX_W   = 24;
  localparam int TRIG_W  = 16;
  localparam int DIM_W   = 9;
  localparam int FRAC_W  = 14;
  localparam int PROD_W  = 26;
  localparam int ACC_W   = 27;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_COS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

  localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] SIN_RESET = 16'sd0;
  localparam logic [DIM_W-1:0]         DIM_RESET = 9'd256;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_angle;
    logic signed [TRIG_W-1:0] sin_angle;
    logic [DIM_W-1:0]         width;
    logic [DIM_W-1:0]         height;
  } irpf_cfg_t;

  // control and sideband of one word at the frame store access stage
  typedef struct packed {
    logic               fetch;
    logic               in_store;
    logic               in_frame;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [PIX_W-1:0]   pixel;
  } irpf_acc_t;

  // zero reads as one, anything above the store limit saturates
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
    logic [12:0] wide;
    logic [DIM_W-1:0] res;
    wide = {4'b0, v};
    res  = v;
    if (v == '0) begin
      res = 9'd1;
    end else if (wide > 13'(maxv)) begin
      res = DIM_W'(maxv);
    end
    return res;
  endfunction

endpackage

FILE: rtl/irpf_cfg_regs.sv
module irpf_cfg_regs
  import irpf_pkg::*;
#(
  parameter int MAX_WIDTH  = IRPF_MAX_WIDTH,
  parameter int MAX_HEIGHT = IRPF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [TRIG_W-1:0]    wr_data,
  output irpf_cfg_t            cfg
);

  irpf_cfg_t cfg_r;
  irpf_cfg_t cfg_nxt;

  // dimensions are kept already clamped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_COS:    cfg_nxt.cos_angle = signed'(wr_data);
        CFG_SIN:    cfg_nxt.sin_angle = signed'(wr_data);
        CFG_WIDTH:  cfg_nxt.width  = clamp_dim(wr_data[DIM_W-1:0], MAX_WIDTH);
        CFG_HEIGHT: cfg_nxt.height = clamp_dim(wr_data[DIM_W-1:0], MAX_HEIGHT);
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_angle <= COS_RESET;
      cfg_r.sin_angle <= SIN_RESET;
      cfg_r.width     <= clamp_dim(DIM_RESET, MAX_WIDTH);
      cfg_r.height    <= clamp_dim(DIM_RESET, MAX_HEIGHT);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/irpf_rotate.sv
module irpf_rotate
  import irpf_pkg::*;
#(
  parameter int MAX_WIDTH  = IRPF_MAX_WIDTH,
  parameter int MAX_HEIGHT = IRPF_MAX_HEIGHT,
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic               clk,
  input  irpf_cfg_t          cfg,
  input  logic               en_b,
  input  logic               en_c,
  input  logic               a_func,
  input  logic [COORD_W-1:0] a_x,
  input  logic [COORD_W-1:0] a_y,
  input  logic [PIX_W-1:0]   a_pix,
  output irpf_acc_t          c_acc,
  output logic [AW-1:0]      c_addr
);

  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;
  logic signed [9:0]  dx;
  logic signed [9:0]  dy;

  logic                     b_func_r;
  logic [COORD_W-1:0]       b_x_r;
  logic [COORD_W-1:0]       b_y_r;
  logic [PIX_W-1:0]         b_pix_r;
  logic signed [PROD_W-1:0] p_xc_r;
  logic signed [PROD_W-1:0] p_ys_r;
  logic signed [PROD_W-1:0] p_xs_r;
  logic signed [PROD_W-1:0] p_yc_r;

  logic signed [ACC_W-1:0] rx;
  logic signed [ACC_W-1:0] ry;
  logic signed [ACC_W-1:0] w_lim;
  logic signed [ACC_W-1:0] h_lim;
  logic                    in_frame;
  logic [DIM_W-1:0]        sx;
  logic [DIM_W-1:0]        sy;
  logic                    in_store;
  logic [AW-1:0]           addr_nxt;
  irpf_acc_t               acc_nxt;

  irpf_acc_t               c_acc_r;
  logic [AW-1:0]           c_addr_r;

  assign cx = cfg.width[DIM_W-1:1];
  assign cy = cfg.height[DIM_W-1:1];
  assign dx = signed'({2'b00, a_x}) - signed'({2'b00, cx});
  assign dy = signed'({2'b00, a_y}) - signed'({2'b00, cy});

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_func_r <= a_func;
      b_x_r    <= a_x;
      b_y_r    <= a_y;
      b_pix_r  <= a_pix;
      p_xc_r   <= PROD_W'(dx * cfg.cos_angle);
      p_ys_r   <= PROD_W'(dy * cfg.sin_angle);
      p_xs_r   <= PROD_W'(dx * cfg.sin_angle);
      p_yc_r   <= PROD_W'(dy * cfg.cos_angle);
    end
  end

  always_comb begin
    rx = ACC_W'(p_xc_r) - ACC_W'(p_ys_r) + signed'({5'b0, cx, {FRAC_W{1'b0}}});
    ry = ACC_W'(p_xs_r) + ACC_W'(p_yc_r) + signed'({5'b0, cy, {FRAC_W{1'b0}}});
    w_lim = signed'({4'b0, cfg.width, {FRAC_W{1'b0}}});
    h_lim = signed'({4'b0, cfg.height, {FRAC_W{1'b0}}});
    in_frame = !rx[ACC_W-1] && (rx < w_lim) && !ry[ACC_W-1] && (ry < h_lim);
    sx = rx[FRAC_W+DIM_W-1:FRAC_W];
    sy = ry[FRAC_W+DIM_W-1:FRAC_W];
    in_store = ({5'b0, b_x_r} < 13'(MAX_WIDTH)) && ({5'b0, b_y_r} < 13'(MAX_HEIGHT));

    // loads go to their own spot, fetches to the rotated source point
    if (b_func_r) begin
      addr_nxt = AW'(32'(sy) * 32'(MAX_WIDTH) + 32'(sx));
    end else begin
      addr_nxt = AW'(32'(b_y_r) * 32'(MAX_WIDTH) + 32'(b_x_r));
    end

    acc_nxt.fetch    = b_func_r;
    acc_nxt.in_store = in_store;
    acc_nxt.in_frame = in_frame;
    acc_nxt.src_x    = in_frame ? sx[COORD_W-1:0] : '0;
    acc_nxt.src_y    = in_frame ? sy[COORD_W-1:0] : '0;
    acc_nxt.pixel    = b_pix_r;
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_acc_r  <= acc_nxt;
      c_addr_r <= addr_nxt;
    end
  end

  assign c_acc  = c_acc_r;
  assign c_addr = c_addr_r;

endmodule

FILE: rtl/irpf_frame_mem.sv
module irpf_frame_mem
  import irpf_pkg::*;
#(
  parameter int DEPTH = IRPF_MAX_WIDTH * IRPF_MAX_HEIGHT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [PIX_W-1:0] wdata,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/image_rotation_pixel_fetch.sv
// Nearest-neighbor rotation of an RGB frame about its center. A load word
// (func 0) writes pixel_in to the frame store at (x_coord, y_coord) and gives
// no result; a fetch word (func 1) rotates the destination point by the Q1.14
// cosine and sine and returns the stored pixel at the truncated source point,
// or black with in_bounds low when it falls outside the frame. One word of
// either kind is taken every clock while the output is not held back; a fetch
// result passes the input register, the product register, the address
// register and the registered read of the single-port frame store before it
// is offered. The store serves one load or one fetch per cycle. The frame
// store is not cleared at reset: fetch only pixels loaded before.
// Configuration writes go through at once and belong to idle periods.
module image_rotation_pixel_fetch
  import irpf_pkg::*;
#(
  parameter int MAX_WIDTH  = IRPF_MAX_WIDTH,
  parameter int MAX_HEIGHT = IRPF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TRIG_W-1:0]    cfg_data,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [COORD_W-1:0]   in_x_coord,
  input  logic [COORD_W-1:0]   in_y_coord,
  input  logic [PIX_W-1:0]     in_pixel_in,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_pixel_out,
  output logic                 out_in_bounds,
  output logic [COORD_W-1:0]   out_src_x,
  output logic [COORD_W-1:0]   out_src_y
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  irpf_cfg_t cfg;

  logic               va_r, vb_r, vc_r, vd_r;
  logic               va_nxt, vb_nxt, vc_nxt, vd_nxt;
  logic               a_func_r;
  logic [COORD_W-1:0] a_x_r;
  logic [COORD_W-1:0] a_y_r;
  logic [PIX_W-1:0]   a_pix_r;

  logic rdy_a, rdy_b, rdy_c, rdy_d;

  irpf_acc_t        c_acc;
  logic [AW-1:0]    c_addr;
  logic             mem_we;
  logic             mem_re;
  logic [PIX_W-1:0] mem_rdata;

  logic               d_inside_r;
  logic [COORD_W-1:0] d_src_x_r;
  logic [COORD_W-1:0] d_src_y_r;

  assign cfg_ready = 1'b1;

  irpf_cfg_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_index(cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // each stage refills when empty or when it hands its word on;
  // a load leaves the access stage without needing the output slot
  always_comb begin
    rdy_d = !vd_r || out_ready;
    rdy_c = !vc_r || !c_acc.fetch || rdy_d;
    rdy_b = !vb_r || rdy_c;
    rdy_a = !va_r || rdy_b;
  end

  assign in_ready = rdy_a;

  always_comb begin
    va_nxt = rdy_a ? in_valid : va_r;
    vb_nxt = rdy_b ? va_r : vb_r;
    vc_nxt = rdy_c ? vb_r : vc_r;
    vd_nxt = rdy_d ? (vc_r && c_acc.fetch) : vd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
      vc_r <= vc_nxt;
      vd_r <= vd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_func_r <= in_func;
      a_x_r    <= in_x_coord;
      a_y_r    <= in_y_coord;
      a_pix_r  <= in_pixel_in;
    end
  end

  irpf_rotate #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_rotate (
    .clk   (clk),
    .cfg   (cfg),
    .en_b  (rdy_b),
    .en_c  (rdy_c),
    .a_func(a_func_r),
    .a_x   (a_x_r),
    .a_y   (a_y_r),
    .a_pix (a_pix_r),
    .c_acc (c_acc),
    .c_addr(c_addr)
  );

  assign mem_we = vc_r && !c_acc.fetch && c_acc.in_store;
  assign mem_re = vc_r && c_acc.fetch && c_acc.in_frame && rdy_d;

  irpf_frame_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (c_addr),
    .wdata(c_acc.pixel),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rdy_d) begin
      d_inside_r <= c_acc.in_frame;
      d_src_x_r  <= c_acc.src_x;
      d_src_y_r  <= c_acc.src_y;
    end
  end

  assign out_valid     = vd_r;
  assign out_in_bounds = d_inside_r;
  assign out_src_x     = d_src_x_r;
  assign out_src_y     = d_src_y_r;
  // read data of an out-of-frame fetch is stale, show black instead
  assign out_pixel_out = d_inside_r ? mem_rdata : '0;

  a_single_port : assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("frame store written and read in one cycle");

  a_full_when_stalled : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (va_r && vb_r && vc_r && vd_r))
    else $error("input stalled with a bubble in the pipeline");

  a_result_from_fetch : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(vd_r) |-> $past(vc_r && c_acc.fetch))
    else $error("result without a fetch behind it");

  a_black_outside : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_bounds) |->
      (out_pixel_out == '0 && out_src_x == '0 && out_src_y == '0))
    else $error("out-of-frame result not black");

endmodule
